[hdl/base64_stream_decoder_assert.svh]
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// shared property forms for the decoder checker
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define B64D_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define B64D_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hdl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types and constants of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int CHAR_W             = 8;
    localparam int BYTE_W             = 8;
    localparam int KIND_W             = 2;
    localparam int GROUP_W            = 24;
    localparam int GROUP_DEPTH_DEFAULT = 4;

    // result kind codes carried on tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // one decoded group: up to three results from a single character
    typedef struct packed {
        logic [GROUP_W-1:0] num;    // bytes, first result in the top bits
        logic [1:0]         count;  // number of results, 1..3
        kind_t              kind;
        logic               last;   // set when the final result of the group ends the stream
    } group_t;

endpackage

[hdl/b64d_group_unit.sv]
// ----------------------------------------------------------------------------
// b64d_group_unit
// character mapping and group state; emits one group per ending character
// ----------------------------------------------------------------------------
module b64d_group_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [b64d_pkg::CHAR_W-1:0]  char_code,
    input  logic                         end_of_input,
    output logic                         push,
    output b64d_pkg::group_t             group
);
    import b64d_pkg::*;

    localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;

    logic [17:0]        group_bits_reg, group_bits_next;
    logic [1:0]         group_position_reg, group_position_next;
    logic [1:0]         pad_count_reg, pad_count_next;
    logic               finished_reg, finished_next;

    logic [5:0]         val;
    logic               is_pad;
    logic               bad;
    logic [2:0]         pads;
    logic [2:0]         pads_tot;
    logic [2:0]         missing;
    logic [2:0]         n;
    logic [GROUP_W-1:0] acc;
    logic [GROUP_W-1:0] num;
    logic               done;

    // alphabet lookup
    always_comb
    begin
        is_pad = 1'b0;
        bad    = 1'b0;
        val    = '0;
        if (char_code == CHAR_PAD)
        begin
            is_pad = 1'b1;
        end
        else if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z)
        begin
            val = 6'(char_code - CHAR_UPPER_A);
        end
        else if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z)
        begin
            val = 6'(char_code - CHAR_LOWER_A + 8'd26);
        end
        else if (char_code >= CHAR_DIGIT_0 && char_code <= CHAR_DIGIT_9)
        begin
            val = 6'(char_code - CHAR_DIGIT_0 + 8'd52);
        end
        else if (char_code == CHAR_PLUS)
        begin
            val = 6'd62;
        end
        else if (char_code == CHAR_SLASH)
        begin
            val = 6'd63;
        end
        else
        begin
            bad = 1'b1;
        end
    end

    // group assembly, missing positions of a short group count as pads
    always_comb
    begin
        pads = {1'b0, pad_count_reg} + {2'b00, is_pad};
        acc  = {group_bits_reg, val};
        n    = {1'b0, group_position_reg} + 3'd1;
        case (n)
            3'd1:
            begin
                num     = {acc[5:0], 18'd0};
                missing = 3'd3;
            end
            3'd2:
            begin
                num     = {acc[11:0], 12'd0};
                missing = 3'd2;
            end
            3'd3:
            begin
                num     = {acc[17:0], 6'd0};
                missing = 3'd1;
            end
            default:
            begin
                num     = acc;
                missing = 3'd0;
            end
        endcase
        pads_tot = pads + missing;
    end

    always_comb
    begin
        group_bits_next     = group_bits_reg;
        group_position_next = group_position_reg;
        pad_count_next      = pad_count_reg;
        finished_next       = finished_reg;
        push                = 1'b0;
        done                = 1'b0;
        group.num           = '0;
        group.count         = 2'd1;
        group.kind          = KIND_DATA;
        group.last          = 1'b0;

        if (accept)
        begin
            if (finished_reg)
            begin
                // ignore until an end-flagged character rearms decoding
                if (end_of_input)
                begin
                    finished_next = 1'b0;
                end
            end
            else if (bad)
            begin
                push                = 1'b1;
                group.kind          = KIND_ERROR;
                group.last          = 1'b1;
                group_bits_next     = '0;
                group_position_next = '0;
                pad_count_next      = '0;
                finished_next       = !end_of_input;
            end
            else if (n < 3'd4 && !end_of_input)
            begin
                group_bits_next     = acc[17:0];
                group_position_next = n[1:0];
                pad_count_next      = pads[1:0];
            end
            else
            begin
                push = 1'b1;
                if (pads_tot > 3'd2)
                begin
                    group.kind = KIND_END;
                    group.last = 1'b1;
                    done       = 1'b1;
                end
                else
                begin
                    done        = (pads_tot != 3'd0) || end_of_input;
                    group.num   = num;
                    group.count = 2'(3'd3 - pads_tot);
                    group.last  = done;
                end
                group_bits_next     = '0;
                group_position_next = '0;
                pad_count_next      = '0;
                finished_next       = done && !end_of_input;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg     <= '0;
            group_position_reg <= '0;
            pad_count_reg      <= '0;
            finished_reg       <= 1'b0;
        end
        else
        begin
            group_bits_reg     <= group_bits_next;
            group_position_reg <= group_position_next;
            pad_count_reg      <= pad_count_next;
            finished_reg       <= finished_next;
        end
    end

endmodule

[hdl/base64_stream_decoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, one character in, decoded bytes out
// ----------------------------------------------------------------------------
// usage
//   slave side s_*: one character per item in s_tdata, s_tlast marks the
//   final character of an encoded stream
//   master side m_*: one result per item; m_tdata is the decoded byte,
//   m_tuser the kind (data, stream ended without byte, invalid character),
//   m_tlast flags the final result of a decoded stream
// throughput
//   one character accepted every cycle while the group queue has room;
//   the results of a character go into the group queue when it is taken
//   and leave from the queue head at one per cycle while m_tready is high
//   a character yields 0 to 3 results; the group queue of GROUP_DEPTH
//   entries absorbs the three-byte bursts, so s_tready drops only when
//   GROUP_DEPTH groups are waiting to be drained
// reset
//   rst_n clears the group state, the queue and the output position;
//   decoding is active afterward
// receiver stall
//   with m_tready low the current result holds steady; characters keep
//   flowing in until the queue fills
// ----------------------------------------------------------------------------
module base64_stream_decoder
#(
    parameter int GROUP_DEPTH = b64d_pkg::GROUP_DEPTH_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [b64d_pkg::CHAR_W-1:0]  s_tdata,   // char_code
    input  logic                         s_tlast,   // end_of_input
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [b64d_pkg::BYTE_W-1:0]  m_tdata,   // data_byte
    output logic [b64d_pkg::KIND_W-1:0]  m_tuser,   // kind
    output logic                         m_tlast    // last
);
    import b64d_pkg::*;

    localparam int PTR_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int CNT_W = $clog2(GROUP_DEPTH + 1);

    logic       s_fire;
    logic       m_fire;
    logic       push;
    logic       pop;
    group_t     new_group;
    group_t     head;

    // queue of decoded groups
    group_t     group_reg [GROUP_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    // position of the current result inside the head group
    logic [1:0] sub_reg, sub_next;

    assign s_tready = (count_reg != CNT_W'(GROUP_DEPTH));
    assign s_fire   = s_tvalid && s_tready;

    b64d_group_unit u_group_unit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (s_fire),
        .char_code    (s_tdata),
        .end_of_input (s_tlast),
        .push         (push),
        .group        (new_group)
    );

    assign head     = group_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last && (sub_reg == head.count - 2'd1);
    assign pop      = m_fire && (sub_reg == head.count - 2'd1);

    // byte select, first result from the top of the group
    always_comb
    begin
        case (sub_reg)
            2'd0:    m_tdata = head.num[23:16];
            2'd1:    m_tdata = head.num[15:8];
            default: m_tdata = head.num[7:0];
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(GROUP_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(GROUP_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            sub_next    = '0;
        end
        else if (m_fire)
        begin
            sub_next = sub_reg + 2'd1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            group_reg[wr_ptr_reg] <= new_group;
        end
    end

endmodule

[hdl/b64d_checker.sv]
// ----------------------------------------------------------------------------
// b64d_checker
// port-level checks of the base64 stream decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_assert.svh"

module b64d_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [b64d_pkg::CHAR_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [b64d_pkg::BYTE_W-1:0]  m_tdata,
    input  logic [b64d_pkg::KIND_W-1:0]  m_tuser,
    input  logic                         m_tlast
);
    import b64d_pkg::*;

    logic in_unused;
    assign in_unused = s_tvalid ^ s_tready ^ s_tlast ^ (^s_tdata);

    // a stalled result holds
    `B64D_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result changed while stalled")

    // end and error results stand alone and carry a zero byte
    `B64D_ASSERT_IMPLY(a_nondata_last, clk, rst_n,
        m_tvalid && (m_tuser != KIND_DATA),
        m_tlast && (m_tdata == '0), "end or error result not last or nonzero")

    // nothing waits on the output right after reset
    `B64D_ASSERT_IMPLY(a_reset_empty, clk, rst_n, $rose(rst_n),
        !m_tvalid, "result pending right after reset")

    // a result appears only after some character was taken
    `B64D_ASSERT_NEXT(a_no_spurious, clk, rst_n,
        !m_tvalid && !(s_tvalid && s_tready),
        !m_tvalid, "result without an accepted character")

endmodule

bind base64_stream_decoder b64d_checker u_checker (.*);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for base64_stream_decoder: characters go in on the
// slave stream, a local decoder model predicts every result, and each result
// taken from the master stream is checked field by field against the oldest
// prediction; both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    // one decoded result as seen on the master stream
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // char_code
    logic        s_tlast;    // end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // data_byte
    logic [1:0]  m_tuser;    // kind
    logic        m_tlast;    // last

    // results still owed by the block, oldest first
    decoded_t decoded_q[$];

    // decoder model state
    logic [17:0] grp_bits;
    logic [1:0]  grp_pos;
    logic [1:0]  grp_pads;
    logic        stream_done;

    int  errors = 0;
    int  live_items = 0;     // items that were not ignored by the block
    int  stall_left = 0;
    bit  send_quiet = 0;     // sender never idles
    bit  recv_quiet = 0;     // receiver never stalls

    base64_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------

    function automatic void push_result(input logic [7:0] data, input kind_t kind,
                                        input logic last);
        decoded_t r;
        r.data = data;
        r.kind = kind;
        r.last = last;
        decoded_q.push_back(r);
    endfunction

    // update the model with one accepted character and queue its results
    function automatic void decode_char(input logic [7:0] c, input logic eoi);
        logic [5:0]  v;
        logic        is_pad;
        logic        bad;
        logic [23:0] acc;
        logic [23:0] num;
        int          n;
        int          pads;
        int          nbytes;
        logic        done;

        v      = '0;
        is_pad = 1'b0;
        bad    = 1'b0;

        // stream already over: swallow everything, an end flag re-arms
        if (stream_done)
        begin
            if (eoi)
            begin
                {grp_bits, grp_pos, grp_pads} = '0;
                stream_done = 1'b0;
            end
            return;
        end

        if (c == "=")
            is_pad = 1'b1;
        else if (c >= "A" && c <= "Z")
            v = 6'(c - "A");
        else if (c >= "a" && c <= "z")
            v = 6'(c - "a" + 8'd26);
        else if (c >= "0" && c <= "9")
            v = 6'(c - "0" + 8'd52);
        else if (c == "+")
            v = 6'd62;
        else if (c == "/")
            v = 6'd63;
        else
            bad = 1'b1;

        // invalid character: one error result, group dropped
        if (bad)
        begin
            push_result(8'h00, KIND_ERROR, 1'b1);
            {grp_bits, grp_pos, grp_pads} = '0;
            stream_done = !eoi;
            return;
        end

        pads = grp_pads + is_pad;
        acc  = {grp_bits, v};
        n    = grp_pos + 1;

        // group not complete and stream goes on: just gather
        if (n < 4 && !eoi)
        begin
            grp_bits = acc[17:0];
            grp_pos  = 2'(n);
            grp_pads = 2'(pads);
            return;
        end

        // missing positions of a cut-short group count as pads
        num  = acc << (6 * (4 - n));
        pads = pads + (4 - n);

        if (pads > 2)
        begin
            push_result(8'h00, KIND_END, 1'b1);
            done = 1'b1;
        end
        else
        begin
            nbytes = 3 - pads;
            done   = (pads != 0) || eoi;
            push_result(num[23:16], KIND_DATA, done && nbytes == 1);
            if (nbytes >= 2)
                push_result(num[15:8], KIND_DATA, done && nbytes == 2);
            if (nbytes == 3)
                push_result(num[7:0], KIND_DATA, done);
        end

        {grp_bits, grp_pos, grp_pads} = '0;
        stream_done = done && !eoi;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26)
            return "A" + v;
        else if (v < 52)
            return "a" + (v - 26);
        else if (v < 62)
            return "0" + (v - 52);
        else if (v == 62)
            return "+";
        else
            return "/";
    endfunction

    // offer one item, wait for the handshake, then update the model;
    // valid is only dropped when a gap follows, so it never toggles in one step
    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        gap = send_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        do @(posedge clk); while (!s_tready);
        if (!stream_done)
            live_items++;
        decode_char(c, eoi);
    endtask

    // send a string of characters, end flag on the final one if asked
    task automatic send_text(input string txt, input bit end_flag);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_char(txt[i], end_flag && i == txt.len() - 1);
    endtask

    // encode random bytes and send them as one stream; padding optional,
    // the end flag either on the final character or on a trailing character
    task automatic send_encoded(input int nbytes, input bit with_pad, input bit late_end);
        logic [7:0]  chars[$];
        logic [23:0] grp;
        int          i;
        int          k;
        int          rem;
        for (i = 0; i < nbytes; i += 3)
        begin
            rem = nbytes - i;
            grp[23:16] = 8'($urandom_range(0, 255));
            grp[15:0]  = 16'($urandom);
            if (rem < 3)
                grp[7:0] = 8'h00;
            if (rem < 2)
                grp[15:8] = 8'h00;
            for (k = 0; k < 4; k++)
            begin
                if (rem >= 3 || k <= rem)
                    chars.push_back(sextet_char(grp[23 - 6*k -: 6]));
                else if (with_pad)
                    chars.push_back("=");
            end
        end
        for (i = 0; i < chars.size(); i++)
            send_char(chars[i], !late_end && i == chars.size() - 1);
        if (late_end)
        begin
            k = $urandom_range(0, 3);
            for (i = 0; i < k; i++)
                send_char(sextet_char(6'($urandom)), 1'b0);
            send_char(8'($urandom), 1'b1);
        end
    endtask

    // stop sending until every owed result has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (decoded_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        send_text("AAAA", 1'b0);          // all-zero group, stream goes on
        send_text("+/z9", 1'b0);          // full group mid stream, last low
        send_text("////", 1'b1);          // all-ones group with end flag
        send_text("QQ", 1'b1);            // short final group, two pads implied
        send_text("A=AA", 1'b0);          // pad inside a group, stream ends
        send_char("x", 1'b0);             // ignored after the end
        send_char("!", 1'b1);             // ignored, re-arms the decoder
        send_text("A===", 1'b1);          // too many pads
        send_char("A", 1'b0);
        send_char(8'hFF, 1'b0);           // invalid character mid group
        send_char(8'h00, 1'b1);           // ignored, re-arms
        send_char(8'h00, 1'b1);           // invalid character with end flag
    endtask

    // sender holds off mid stream until the block has nothing left to give
    task automatic test_pause();
        send_text("TW", 1'b0);
        wait_drained();
        send_text("FuTW", 1'b0);
        wait_drained();
        send_text("E=", 1'b1);
    endtask

    // back-to-back items; second stream lets the receiver stall and fill the queue
    task automatic test_back_to_back();
        send_quiet = 1;
        recv_quiet = 1;
        send_encoded(12, 1'b1, 1'b0);
        recv_quiet = 0;
        send_encoded(15, 1'b0, 1'b0);
        send_encoded(8, 1'b1, 1'b0);
        send_quiet = 0;
    endtask

    // mostly well-formed streams with random content, the rest noise
    task automatic test_random();
        int start;
        int len;
        int i;
        int r;
        logic [7:0] c;
        start = live_items;
        while (live_items - start < 45)
        begin
            if ($urandom_range(0, 99) < 65)
            begin
                send_encoded($urandom_range(1, 10), $urandom_range(0, 3) != 0,
                             $urandom_range(0, 4) == 0);
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        c = sextet_char(6'($urandom));
                    else if (r < 75)
                        c = "=";
                    else
                        c = 8'($urandom);
                    send_char(c, $urandom_range(0, 5) == 0 || i == len - 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, driven at the rising edge
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (stall_left == 0 && !recv_quiet && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, %s %02h kind %0d last %0b",
                         $time, "actual data", m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.data)
                begin
                    $display("%0t: data_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.kind)
                begin
                    $display("%0t: kind mismatch: expected %0d, actual %0d",
                             $time, want.kind, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        {grp_bits, grp_pos, grp_pads} = '0;
        stream_done = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pause();
        test_back_to_back();
        test_random();

        // let everything drain, then watch a while for stray results
        wait_drained();
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("base64_stream_decoder test passed");
        else
            $display("base64_stream_decoder test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("base64_stream_decoder test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/b64d_pkg.sv
hdl/b64d_group_unit.sv
hdl/base64_stream_decoder.sv
hdl/b64d_checker.sv
test/tb_top.sv
